### src/gcd_pkg.sv
// ---------------------------------------------------------------------------
// gcd_pkg: shared constants and arithmetic helpers
// Fixed-point formats and helpers for the great-circle distance pipeline.
// ---------------------------------------------------------------------------
package gcd_pkg;

  // field widths
  localparam int LAT_W    = 24;
  localparam int LON_W    = 25;
  localparam int RADIUS_W = 24;
  localparam int DIST_W   = 24;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd1630976;
  localparam logic [DIST_W-1:0]   DIST_MAX     = 24'hFF_FFFF;

  // degree to binary angle conversion: x = deg + 45 * 2^20, q = x / 45
  localparam int             DEG_W      = 26;
  localparam logic [25:0]    DEG_OFFSET = 26'd47185920;
  localparam logic [26:0]    RECIP_45   = 27'd95443718;
  localparam logic [5:0]     DIV_45     = 6'd45;
  localparam logic [12:0]    FRAC_STEP  = 13'd182;
  localparam logic [5:0]     FRAC_LO    = 6'd12;
  localparam logic [5:0]     FRAC_HI    = 6'd34;

  // binary angles and sine format
  localparam int              BAM_W   = 32;
  localparam int              U_W     = 31;
  localparam logic [31:0]     QUARTER = 32'h4000_0000;
  localparam logic [U_W-1:0]  U_ONE   = 31'h4000_0000;

  // quarter-wave sine polynomial
  localparam int QSIN_LAT     = 8;
  localparam int HORNER_STEPS = 6;
  localparam logic signed [32:0] SC13 = 33'sd61;
  localparam logic signed [32:0] HORNER_ADD [HORNER_STEPS] = '{
    -33'sd3864, 33'sd172272, -33'sd5026995,
    33'sd85569306, -33'sd693598668, 33'sd1686629713
  };

  // haversine term, root and arcsine
  localparam int          A_W        = 61;
  localparam int          V_W        = 60;
  localparam int          ROOT_W     = 30;
  localparam int          ASIN_STEPS = 30;
  localparam logic [60:0] A_ONE      = 61'h1000_0000_0000_0000;
  localparam logic [60:0] A_HALF     = 61'h0800_0000_0000_0000;
  localparam logic [31:0] PI_Q30     = 32'd3373259426;

  // q30 product, magnitude rounded half away from zero
  function automatic logic signed [32:0] mulq(input logic signed [32:0] a,
                                              input logic signed [32:0] b);
    logic        neg;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] prod;
    logic [63:0] rnd;
    logic [32:0] mag;
    neg  = a[32] ^ b[32];
    ma   = a[32] ? 32'(-a) : 32'(a);
    mb   = b[32] ? 32'(-b) : 32'(b);
    prod = ma * mb;
    rnd  = prod + 64'd536870912;
    mag  = rnd[62:30];
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  // quadrant folding of a binary angle into the quarter-wave argument
  function automatic logic [U_W-1:0] bam_to_u(input logic [BAM_W-1:0] b);
    logic [U_W-1:0] x;
    x = {1'b0, b[29:0]};
    return b[30] ? U_ONE - x : x;
  endfunction

  // low binary-angle bits from the remainder of deg / 45
  function automatic logic [12:0] deg_frac(input logic [5:0] r);
    logic [12:0] base;
    logic [12:0] adj;
    base = 13'(r) * FRAC_STEP;
    adj  = (r >= FRAC_HI) ? 13'd2 : ((r >= FRAC_LO) ? 13'd1 : 13'd0);
    return base + adj;
  endfunction

endpackage

### src/gcd_point_if.sv
// ---------------------------------------------------------------------------
// gcd_point_if: point pair channel
// Two latitude/longitude pairs with valid/ready handshake.
// ---------------------------------------------------------------------------
interface gcd_point_if;
  logic                               valid;
  logic                               ready;
  logic signed [gcd_pkg::LAT_W-1:0]   first_lat;
  logic signed [gcd_pkg::LON_W-1:0]   first_lon;
  logic signed [gcd_pkg::LAT_W-1:0]   second_lat;
  logic signed [gcd_pkg::LON_W-1:0]   second_lon;

  modport source (output valid, first_lat, first_lon, second_lat, second_lon,
                  input ready);
  modport sink (input valid, first_lat, first_lon, second_lat, second_lon,
                output ready);
endinterface

### src/gcd_dist_if.sv
// ---------------------------------------------------------------------------
// gcd_dist_if: distance result channel
// One distance per beat with valid/ready handshake.
// ---------------------------------------------------------------------------
interface gcd_dist_if;
  logic                          valid;
  logic                          ready;
  logic [gcd_pkg::DIST_W-1:0]    distance;

  modport source (output valid, distance, input ready);
  modport sink (input valid, distance, output ready);
endinterface

### src/gcd_cfg_if.sv
// ---------------------------------------------------------------------------
// gcd_cfg_if: radius write channel
// Write data for the sphere radius register with valid/ready handshake.
// ---------------------------------------------------------------------------
interface gcd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [gcd_pkg::RADIUS_W-1:0]   sphere_radius;

  modport source (output valid, sphere_radius, input ready);
  modport sink (input valid, sphere_radius, output ready);
endinterface

### src/gcd_delay.sv
// ---------------------------------------------------------------------------
// gcd_delay: stallable delay line
// Carries valid bits and side data alongside a pipelined unit.
// ---------------------------------------------------------------------------
module gcd_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic [W-1:0] d_in,
  output logic [W-1:0] d_out
);

  logic [W-1:0] pipe [DEPTH];

  // shift on every advancing cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) pipe[i] <= '0;
    end else if (en) begin
      pipe[0] <= d_in;
      for (int i = 1; i < DEPTH; i++) pipe[i] <= pipe[i-1];
    end
  end

  assign d_out = pipe[DEPTH-1];

endmodule

### src/gcd_qsin.sv
// ---------------------------------------------------------------------------
// gcd_qsin: pipelined quarter-wave sine
// Odd degree-13 polynomial by Horner, one q30 product per stage, 8 stages.
// ---------------------------------------------------------------------------
module gcd_qsin (
  input  logic                   clk,
  input  logic                   en,
  input  logic [gcd_pkg::U_W-1:0] u_in,
  output logic [gcd_pkg::U_W-1:0] s_out
);

  localparam int NH = gcd_pkg::HORNER_STEPS;

  logic signed [32:0] u_ext;
  logic signed [32:0] u_r  [NH+1];
  logic signed [32:0] u2_r [NH];
  logic signed [32:0] p_r  [NH];
  logic signed [32:0] p_fin;

  assign u_ext = $signed({2'b00, u_in});

  // square of the argument
  always_ff @(posedge clk) begin
    if (en) begin
      u_r[0]  <= u_ext;
      u2_r[0] <= gcd_pkg::mulq(u_ext, u_ext);
    end
  end

  // horner steps
  for (genvar k = 0; k < NH; k++) begin : g_horner
    logic signed [32:0] p_src;
    if (k == 0) begin : g_first
      assign p_src = gcd_pkg::SC13;
    end else begin : g_rest
      assign p_src = p_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        p_r[k]   <= gcd_pkg::mulq(p_src, u2_r[k]) + gcd_pkg::HORNER_ADD[k];
        u_r[k+1] <= u_r[k];
      end
    end

    if (k < NH - 1) begin : g_u2
      always_ff @(posedge clk) begin
        if (en) u2_r[k+1] <= u2_r[k];
      end
    end
  end

  // final odd factor and clamp to [0, 1]
  assign p_fin = gcd_pkg::mulq(p_r[NH-1], u_r[NH]);

  always_ff @(posedge clk) begin
    if (en) begin
      if (p_fin < 0) begin
        s_out <= '0;
      end else if (p_fin > $signed({2'b00, gcd_pkg::U_ONE})) begin
        s_out <= gcd_pkg::U_ONE;
      end else begin
        s_out <= p_fin[gcd_pkg::U_W-1:0];
      end
    end
  end

endmodule

### src/gcd_isqrt.sv
// ---------------------------------------------------------------------------
// gcd_isqrt: pipelined integer square root
// Digit-by-digit root of a 60-bit value, one result bit per stage.
// ---------------------------------------------------------------------------
module gcd_isqrt (
  input  logic                      clk,
  input  logic                      en,
  input  logic [gcd_pkg::V_W-1:0]   v_in,
  output logic [gcd_pkg::ROOT_W-1:0] root_out
);

  localparam int N = gcd_pkg::ROOT_W;
  localparam int W = gcd_pkg::V_W;

  logic [W-1:0] rem_r [N-1];
  logic [W-1:0] res_r [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic [W-1:0] BIT = W'(1) << (2 * (N - 1 - i));
    logic [W-1:0] rem_src;
    logic [W-1:0] res_src;
    logic [W-1:0] trial;
    logic         take;

    if (i == 0) begin : g_first
      assign rem_src = v_in;
      assign res_src = '0;
    end else begin : g_rest
      assign rem_src = rem_r[i-1];
      assign res_src = res_r[i-1];
    end

    assign trial = res_src + BIT;
    assign take  = rem_src >= trial;

    // root bit decision
    always_ff @(posedge clk) begin
      if (en) res_r[i] <= take ? (res_src >> 1) + BIT : res_src >> 1;
    end

    if (i < N - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) rem_r[i] <= take ? rem_src - trial : rem_src;
      end
    end
  end

  assign root_out = res_r[N-1][N-1:0];

endmodule

### src/gcd_asin.sv
// ---------------------------------------------------------------------------
// gcd_asin: pipelined arcsine search
// Bitwise search for the largest angle whose sine is at most the input,
// one sine evaluation and one decision register per result bit.
// ---------------------------------------------------------------------------
module gcd_asin #(
  parameter int TAG_W = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic [gcd_pkg::ROOT_W-1:0] r_in,
  input  logic [TAG_W-1:0]           tag_in,
  output logic [gcd_pkg::ROOT_W-1:0] theta_out,
  output logic [TAG_W-1:0]           tag_out
);

  localparam int N = gcd_pkg::ASIN_STEPS;
  localparam int W = gcd_pkg::ROOT_W;

  logic [W-1:0]     theta_r [N];
  logic [W-1:0]     r_r     [N-1];
  logic [TAG_W-1:0] tag_r   [N];

  for (genvar j = 0; j < N; j++) begin : g_step
    localparam logic [W-1:0] BIT = W'(1) << (N - 1 - j);
    logic [W-1:0]           theta_src;
    logic [W-1:0]           r_src;
    logic [TAG_W-1:0]       tag_src;
    logic [W-1:0]           theta_d;
    logic [W-1:0]           r_d;
    logic [TAG_W-1:0]       tag_d;
    logic [gcd_pkg::U_W-1:0] s;

    if (j == 0) begin : g_first
      assign theta_src = '0;
      assign r_src     = r_in;
      assign tag_src   = tag_in;
    end else begin : g_rest
      assign theta_src = theta_r[j-1];
      assign r_src     = r_r[j-1];
      assign tag_src   = tag_r[j-1];
    end

    // sine of the candidate angle
    gcd_qsin u_qsin (
      .clk   (clk),
      .en    (en),
      .u_in  ({1'b0, theta_src | BIT}),
      .s_out (s)
    );

    // search state alongside the sine unit
    gcd_delay #(
      .W     (2 * W + TAG_W),
      .DEPTH (gcd_pkg::QSIN_LAT)
    ) u_dly (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .d_in  ({theta_src, r_src, tag_src}),
      .d_out ({theta_d, r_d, tag_d})
    );

    // keep the bit when the sine does not exceed the target
    always_ff @(posedge clk) begin
      if (rst) begin
        tag_r[j] <= '0;
      end else if (en) begin
        tag_r[j]   <= tag_d;
        theta_r[j] <= (s <= {1'b0, r_d}) ? (theta_d | BIT) : theta_d;
      end
    end

    if (j < N - 1) begin : g_r
      always_ff @(posedge clk) begin
        if (en) r_r[j] <= r_d;
      end
    end
  end

  assign theta_out = theta_r[N-1];
  assign tag_out   = tag_r[N-1];

endmodule

### src/great_circle_distance.sv
// ---------------------------------------------------------------------------
// great_circle_distance: haversine distance pipeline
// Converts two points to binary angles, evaluates the haversine term,
// takes root and arcsine, and scales the central angle by the radius.
// ---------------------------------------------------------------------------
//
//  channel   dir   payload                                       width
//  points    in    first_lat, first_lon, second_lat, second_lon  24/25/24/25
//  result    out   distance                                      24
//  cfg       in    sphere_radius                                 24
//
//  one beat enters per cycle while not stalled; most of the depth lies in
//  the 30 arcsine search steps of 9 stages each (one sine pipeline per step)
//  reset clears all valid bits and loads the radius with 6371 km
//  a result held at the output stalls the whole pipeline; nothing moves,
//  nothing is lost, and points.ready follows result.ready while a result waits
//  cfg is always ready; a radius write applies to every item not yet
//  past the radius scaling stage
// ---------------------------------------------------------------------------
module great_circle_distance (
  input  logic         clk,
  input  logic         rst,
  gcd_point_if.sink    points,
  gcd_dist_if.source   result,
  gcd_cfg_if.sink      cfg
);

  logic en;

  logic [gcd_pkg::RADIUS_W-1:0] radius;

  logic        v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11, v12, v13;

  logic [25:0] x0    [4];
  logic [52:0] prod1 [4];
  logic [18:0] q1    [4];
  logic [5:0]  x1    [4];
  logic [31:0] bam2  [4];

  logic [31:0]              dlat;
  logic [31:0]              dlon;
  logic [31:0]              c1b;
  logic [31:0]              c2b;
  logic [gcd_pkg::U_W-1:0]  u3 [4];
  logic                     cneg3;

  logic [gcd_pkg::U_W-1:0]  s4 [4];
  logic                     v_s;
  logic                     cneg_s;

  logic signed [32:0]       ccm;
  logic signed [32:0]       cc4;
  logic [gcd_pkg::U_W-1:0]  slat4;
  logic [gcd_pkg::U_W-1:0]  slon4;
  logic signed [32:0]       t5;
  logic [61:0]              sq5;
  logic [gcd_pkg::U_W-1:0]  slon5;
  logic signed [63:0]       prod_c;
  logic signed [63:0]       prod6;
  logic [61:0]              sq6;
  logic signed [63:0]       sum_c;
  logic [gcd_pkg::A_W-1:0]  a7;
  logic [gcd_pkg::V_W-1:0]  sq_in8;
  logic                     flip8;

  logic [gcd_pkg::ROOT_W-1:0] root;
  logic                       v_q;
  logic                       flip_q;
  logic [gcd_pkg::ROOT_W-1:0] theta;
  logic                       v_a;
  logic                       flip_a;

  logic [gcd_pkg::U_W-1:0]   th9;
  logic [62:0]               angp10;
  logic [62:0]               angr;
  logic [31:0]               ang11;
  logic [55:0]               dp12;
  logic [55:0]               dr;
  logic [25:0]               dq;
  logic [gcd_pkg::DIST_W-1:0] dist13;

  // whole pipeline advances unless the output holds an untaken beat
  assign en              = !v13 || result.ready;
  assign points.ready    = en;
  assign result.valid    = v13;
  assign result.distance = dist13;
  assign cfg.ready       = 1'b1;

  // radius register
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= gcd_pkg::RADIUS_RESET;
    end else if (cfg.valid) begin
      radius <= cfg.sphere_radius;
    end
  end

  // stage 1: offset degrees and reciprocal multiply for deg / 45
  always_comb begin
    x0[0] = 26'(points.first_lat) + gcd_pkg::DEG_OFFSET;
    x0[1] = 26'(points.first_lon) + gcd_pkg::DEG_OFFSET;
    x0[2] = 26'(points.second_lat) + gcd_pkg::DEG_OFFSET;
    x0[3] = 26'(points.second_lon) + gcd_pkg::DEG_OFFSET;
    for (int i = 0; i < 4; i++) prod1[i] = x0[i] * gcd_pkg::RECIP_45;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        q1[i] <= prod1[i][50:32];
        x1[i] <= x0[i][5:0];
      end
    end
  end

  // stage 2: remainder and binary angle assembly
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        bam2[i] <= {q1[i], gcd_pkg::deg_frac(x1[i] - 6'(q1[i][5:0] * gcd_pkg::DIV_45))};
      end
    end
  end

  // stage 3: half differences, cosine phase shift, quadrant folding
  assign dlat = bam2[2] - bam2[0];
  assign dlon = bam2[3] - bam2[1];
  assign c1b  = bam2[0] + gcd_pkg::QUARTER;
  assign c2b  = bam2[2] + gcd_pkg::QUARTER;

  always_ff @(posedge clk) begin
    if (en) begin
      u3[0] <= gcd_pkg::bam_to_u({1'b0, dlat[31:1]});
      u3[1] <= gcd_pkg::bam_to_u({1'b0, dlon[31:1]});
      u3[2] <= gcd_pkg::bam_to_u(c1b);
      u3[3] <= gcd_pkg::bam_to_u(c2b);
      cneg3 <= c1b[31] ^ c2b[31];
    end
  end

  // four sine units in parallel
  for (genvar i = 0; i < 4; i++) begin : g_sin
    gcd_qsin u_qsin (
      .clk   (clk),
      .en    (en),
      .u_in  (u3[i]),
      .s_out (s4[i])
    );
  end

  gcd_delay #(
    .W     (2),
    .DEPTH (gcd_pkg::QSIN_LAT)
  ) u_dly_sin (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .d_in  ({v3, cneg3}),
    .d_out ({v_s, cneg_s})
  );

  // stage 4: cosine product
  assign ccm = gcd_pkg::mulq($signed({2'b00, s4[2]}), $signed({2'b00, s4[3]}));

  always_ff @(posedge clk) begin
    if (en) begin
      cc4   <= cneg_s ? -ccm : ccm;
      slat4 <= s4[0];
      slon4 <= s4[1];
    end
  end

  // stage 5: longitude term scaled by cosines, latitude term squared
  always_ff @(posedge clk) begin
    if (en) begin
      t5    <= gcd_pkg::mulq($signed({2'b00, slon4}), cc4);
      sq5   <= slat4 * slat4;
      slon5 <= slon4;
    end
  end

  // stage 6: second longitude factor
  assign prod_c = $signed({2'b00, slon5}) * t5;

  always_ff @(posedge clk) begin
    if (en) begin
      prod6 <= prod_c;
      sq6   <= sq5;
    end
  end

  // stage 7: haversine term clamped to [0, 1]
  assign sum_c = $signed({2'b00, sq6}) + prod6;

  always_ff @(posedge clk) begin
    if (en) begin
      if (sum_c < 0) begin
        a7 <= '0;
      end else if (sum_c > $signed({3'b000, gcd_pkg::A_ONE})) begin
        a7 <= gcd_pkg::A_ONE;
      end else begin
        a7 <= sum_c[gcd_pkg::A_W-1:0];
      end
    end
  end

  // stage 8: fold the upper half onto 1 - a
  always_ff @(posedge clk) begin
    if (en) begin
      flip8  <= a7 > gcd_pkg::A_HALF;
      sq_in8 <= (a7 > gcd_pkg::A_HALF) ? gcd_pkg::V_W'(gcd_pkg::A_ONE - a7)
                                       : a7[gcd_pkg::V_W-1:0];
    end
  end

  // root
  gcd_isqrt u_isqrt (
    .clk      (clk),
    .en       (en),
    .v_in     (sq_in8),
    .root_out (root)
  );

  gcd_delay #(
    .W     (2),
    .DEPTH (gcd_pkg::ROOT_W)
  ) u_dly_root (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .d_in  ({v8, flip8}),
    .d_out ({v_q, flip_q})
  );

  // arcsine
  gcd_asin #(
    .TAG_W (2)
  ) u_asin (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .r_in      (root),
    .tag_in    ({v_q, flip_q}),
    .theta_out (theta),
    .tag_out   ({v_a, flip_a})
  );

  // stage 9: unfold to quarter turn minus angle
  always_ff @(posedge clk) begin
    if (en) th9 <= flip_a ? gcd_pkg::U_ONE - {1'b0, theta} : {1'b0, theta};
  end

  // stage 10: angle in radians
  always_ff @(posedge clk) begin
    if (en) angp10 <= th9 * gcd_pkg::PI_Q30;
  end

  // stage 11: round the radian angle
  assign angr = angp10 + 63'd536870912;

  always_ff @(posedge clk) begin
    if (en) ang11 <= angr[61:30];
  end

  // stage 12: radius scaling
  always_ff @(posedge clk) begin
    if (en) dp12 <= radius * ang11;
  end

  // stage 13: round and saturate into the output register
  assign dr = dp12 + 56'd536870912;
  assign dq = dr[55:30];

  always_ff @(posedge clk) begin
    if (en) dist13 <= (dq > 26'(gcd_pkg::DIST_MAX)) ? gcd_pkg::DIST_MAX : dq[23:0];
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
      v5  <= 1'b0;
      v6  <= 1'b0;
      v7  <= 1'b0;
      v8  <= 1'b0;
      v9  <= 1'b0;
      v10 <= 1'b0;
      v11 <= 1'b0;
      v12 <= 1'b0;
      v13 <= 1'b0;
    end else if (en) begin
      v1  <= points.valid;
      v2  <= v1;
      v3  <= v2;
      v4  <= v_s;
      v5  <= v4;
      v6  <= v5;
      v7  <= v6;
      v8  <= v7;
      v9  <= v_a;
      v10 <= v9;
      v11 <= v10;
      v12 <= v11;
      v13 <= v12;
    end
  end

`ifndef SYNTHESIS
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (points.valid && points.ready) |=> v1)
    else $error("accepted beat did not enter the pipeline");

  a_term_clamped: assert property (@(posedge clk) disable iff (rst)
    v7 |-> (a7 <= gcd_pkg::A_ONE))
    else $error("haversine term out of range");

  a_fold_half: assert property (@(posedge clk) disable iff (rst)
    v8 |-> ({1'b0, sq_in8} <= gcd_pkg::A_HALF))
    else $error("root operand above one half");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    v9 |-> (th9 <= gcd_pkg::U_ONE))
    else $error("half angle above quarter turn");
`endif

endmodule
